### src/efg_pkg.sv
package efg_pkg;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_WAIT   = 2'd2,
        CMD_CANCEL = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        KIND_DONE      = 3'd0,
        KIND_MET       = 3'd1,
        KIND_ENQUEUED  = 3'd2,
        KIND_FAILED    = 3'd3,
        KIND_WOKEN     = 3'd4,
        KIND_CANCELLED = 3'd5
    } t_kind;

    typedef struct packed {
        t_cmd_code   command;
        logic [31:0] bits;
        logic [3:0]  task_id;
        logic        wait_all;
        logic        clear_on_exit;
        logic        no_block;
        logic [7:0]  task_priority;
        logic [7:0]  current_priority;
        logic        current_valid;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  woken_task;
        logic [31:0] returned_bits;
        logic [31:0] flag_word;
        logic        preempt;
        logic        last;
    } t_res;

endpackage

### src/efg_if.sv
interface efg_cmd_if;
    logic            valid;
    logic            ready;
    efg_pkg::t_cmd   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface efg_res_if;
    logic            valid;
    logic            ready;
    efg_pkg::t_res   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/event_flag_group_with_waiters.sv
// Clear, wait and a cancel of a task that is not waiting: one result each.
// Set: the command is accepted, then each queued waiter is handled in turn
// (arrival-order read, then waiter-table read and test), then the closing item.
// Cancel of a waiting task walks the queue the same way.
// One command is in flight at a time; a result register decouples the output.
// Synchronous active-low reset clears the flags, queue count and waiting bits.
module event_flag_group_with_waiters #(
    parameter int MAX_TASKS  = 16,
    parameter int FLAG_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efg_cmd_if.sink   i_cmd,
    efg_res_if.source o_res
);

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int WW = FLAG_WIDTH + 10;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RDA  = 5'b00010,
        S_RDW  = 5'b00100,
        S_EVAL = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [FLAG_WIDTH-1:0] r_flag, n_flag;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_rp, n_rp;
    logic [CW-1:0]         r_wp, n_wp;
    logic [MAX_TASKS-1:0]  r_waiting, n_waiting;
    logic [TW-1:0]         r_t, n_t;
    logic [TW-1:0]         r_tid, n_tid;
    logic                  r_set, n_set;
    logic                  r_pre, n_pre;
    logic [7:0]            r_cprio, n_cprio;
    logic                  r_cvalid, n_cvalid;
    efg_pkg::t_res         r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    // arrival order queue and per-task waiter table
    logic [TW-1:0] arr_mem [MAX_TASKS];
    logic [TW-1:0] arr_q;
    logic          arr_we, arr_re;
    logic [TW-1:0] arr_wa, arr_ra, arr_wd;
    logic [WW-1:0] wt_mem [MAX_TASKS];
    logic [WW-1:0] wt_q;
    logic          wt_we, wt_re;
    logic [TW-1:0] wt_wa, wt_ra;
    logic [WW-1:0] wt_wd;

    always_ff @(posedge i_clk) begin
        if (arr_we) begin
            arr_mem[arr_wa] <= arr_wd;
        end
        if (arr_re) begin
            arr_q <= arr_mem[arr_ra];
        end
        if (wt_we) begin
            wt_mem[wt_wa] <= wt_wd;
        end
        if (wt_re) begin
            wt_q <= wt_mem[wt_ra];
        end
    end

    logic [63:0]           w_bits64;
    logic [FLAG_WIDTH-1:0] w_bits;
    logic [31:0]           w_tid32;
    logic [TW-1:0]         w_tid;
    logic                  w_tid_ok;
    logic                  w_acc;
    logic                  w_slot;
    logic [FLAG_WIDTH-1:0] w_hit_in;
    logic                  w_met_in;
    logic [FLAG_WIDTH-1:0] w_mask;
    logic                  w_mall;
    logic                  w_mclr;
    logic [7:0]            w_mprio;
    logic [FLAG_WIDTH-1:0] w_hit_q;
    logic                  w_met_q;
    logic                  w_drop;
    logic [CW-1:0]         w_rp1;
    logic [63:0]           w_flag64;
    logic [31:0]           w_t32;

    assign w_bits64 = {32'd0, i_cmd.payload.bits};
    assign w_bits   = w_bits64[FLAG_WIDTH-1:0];
    assign w_tid32  = {28'd0, i_cmd.payload.task_id};
    assign w_tid    = w_tid32[TW-1:0];
    assign w_tid_ok = (w_tid32 < 32'(MAX_TASKS));
    assign w_slot   = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_slot;
    assign w_acc    = i_cmd.valid && i_cmd.ready;
    assign w_hit_in = r_flag & w_bits;
    assign w_met_in = i_cmd.payload.wait_all ? (w_hit_in == w_bits) : (|w_hit_in);
    assign w_mask   = wt_q[WW-1:10];
    assign w_mall   = wt_q[9];
    assign w_mclr   = wt_q[8];
    assign w_mprio  = wt_q[7:0];
    assign w_hit_q  = r_flag & w_mask;
    assign w_met_q  = w_mall ? (w_hit_q == w_mask) : (|w_hit_q);
    assign w_drop   = r_set ? w_met_q : (r_t == r_tid);
    assign w_rp1    = r_rp + CW'(1);
    assign w_t32    = 32'(r_t);

    always_comb begin
        n_state     = r_state;
        n_flag      = r_flag;
        n_count     = r_count;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_waiting   = r_waiting;
        n_t         = r_t;
        n_tid       = r_tid;
        n_set       = r_set;
        n_pre       = r_pre;
        n_cprio     = r_cprio;
        n_cvalid    = r_cvalid;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        arr_we = 1'b0;
        arr_re = 1'b0;
        arr_wa = '0;
        arr_ra = '0;
        arr_wd = '0;
        wt_we  = 1'b0;
        wt_re  = 1'b0;
        wt_wa  = '0;
        wt_ra  = '0;
        wt_wd  = '0;
        w_flag64 = '0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_tid    = w_tid;
                    n_cprio  = i_cmd.payload.current_priority;
                    n_cvalid = i_cmd.payload.current_valid;
                    n_pre    = 1'b0;
                    n_rp     = '0;
                    n_wp     = '0;
                    n_out.woken_task    = i_cmd.payload.task_id;
                    n_out.returned_bits = '0;
                    n_out.preempt       = 1'b0;
                    n_out.last          = 1'b1;
                    n_out.kind          = efg_pkg::KIND_DONE;
                    case (i_cmd.payload.command)
                        efg_pkg::CMD_SET: begin
                            n_flag = r_flag | w_bits;
                            n_set  = 1'b1;
                            if (r_count == '0) begin
                                n_state = S_FIN;
                            end else begin
                                arr_re  = 1'b1;
                                n_state = S_RDW;
                            end
                        end
                        efg_pkg::CMD_CLEAR: begin
                            n_flag      = r_flag & ~w_bits;
                            n_out_valid = 1'b1;
                        end
                        efg_pkg::CMD_WAIT: begin
                            n_out_valid = 1'b1;
                            n_out.kind  = efg_pkg::KIND_FAILED;
                            if (w_bits == '0 || !i_cmd.payload.current_valid || !w_tid_ok
                                || r_waiting[w_tid]) begin
                                n_out.kind = efg_pkg::KIND_FAILED;
                            end else if (w_met_in) begin
                                n_out.kind = efg_pkg::KIND_MET;
                                w_flag64   = 64'(r_flag);
                                n_out.returned_bits = w_flag64[31:0];
                                if (i_cmd.payload.clear_on_exit) begin
                                    n_flag = r_flag & ~w_bits;
                                end
                            end else if (i_cmd.payload.no_block
                                         || r_count >= CW'(MAX_TASKS)) begin
                                n_out.kind = efg_pkg::KIND_FAILED;
                            end else begin
                                n_out.kind = efg_pkg::KIND_ENQUEUED;
                                wt_we  = 1'b1;
                                wt_wa  = w_tid;
                                wt_wd  = {w_bits, i_cmd.payload.wait_all,
                                          i_cmd.payload.clear_on_exit,
                                          i_cmd.payload.task_priority};
                                arr_we = 1'b1;
                                arr_wa = r_count[TW-1:0];
                                arr_wd = w_tid;
                                n_waiting[w_tid] = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        efg_pkg::CMD_CANCEL: begin
                            if (w_tid_ok && r_waiting[w_tid]) begin
                                n_set   = 1'b0;
                                arr_re  = 1'b1;
                                n_state = S_RDW;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                    w_flag64 = 64'(n_flag);
                    n_out.flag_word = w_flag64[31:0];
                end
            end
            S_RDA: begin
                arr_re  = 1'b1;
                arr_ra  = r_rp[TW-1:0];
                n_state = S_RDW;
            end
            S_RDW: begin
                n_t     = arr_q;
                wt_re   = 1'b1;
                wt_ra   = arr_q;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!(r_set && w_met_q && !w_slot)) begin
                    if (w_drop) begin
                        n_waiting[r_t] = 1'b0;
                        if (r_set) begin
                            if (w_mclr) begin
                                n_flag = r_flag & ~w_mask;
                            end
                            if (r_cvalid && w_mprio < r_cprio) begin
                                n_pre = 1'b1;
                            end
                            n_out_valid = 1'b1;
                            n_out.kind  = efg_pkg::KIND_WOKEN;
                            n_out.woken_task = w_t32[3:0];
                            w_flag64 = 64'(r_flag);
                            n_out.returned_bits = w_flag64[31:0];
                            w_flag64 = 64'(n_flag);
                            n_out.flag_word = w_flag64[31:0];
                            n_out.preempt   = 1'b0;
                            n_out.last      = 1'b0;
                        end
                    end else begin
                        arr_we = 1'b1;
                        arr_wa = r_wp[TW-1:0];
                        arr_wd = r_t;
                        n_wp   = r_wp + CW'(1);
                    end
                    n_rp = w_rp1;
                    if (w_rp1 == r_count) begin
                        n_state = S_FIN;
                    end else begin
                        arr_re  = 1'b1;
                        arr_ra  = w_rp1[TW-1:0];
                        n_state = S_RDW;
                    end
                end
            end
            S_FIN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_count     = r_wp;
                    w_flag64    = 64'(r_flag);
                    n_out.flag_word     = w_flag64[31:0];
                    n_out.returned_bits = '0;
                    n_out.last          = 1'b1;
                    if (r_set) begin
                        n_out.kind       = efg_pkg::KIND_DONE;
                        n_out.woken_task = '0;
                        n_out.preempt    = r_pre;
                    end else begin
                        n_out.kind       = efg_pkg::KIND_CANCELLED;
                        n_out.woken_task = w_t32[3:0] & 4'd0 | 4'(32'(r_tid));
                        n_out.preempt    = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flag      <= '0;
            r_count     <= '0;
            r_waiting   <= '0;
            r_out_valid <= 1'b0;
            r_set       <= 1'b0;
            r_pre       <= 1'b0;
            r_rp        <= '0;
            r_wp        <= '0;
        end else begin
            r_state     <= n_state;
            r_flag      <= n_flag;
            r_count     <= n_count;
            r_waiting   <= n_waiting;
            r_out_valid <= n_out_valid;
            r_set       <= n_set;
            r_pre       <= n_pre;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_tid    <= n_tid;
        r_cprio  <= n_cprio;
        r_cvalid <= n_cvalid;
        r_out    <= n_out;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("waiter count beyond table size");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_waiting) == 32'(r_count)))
        else $error("waiting bits disagree with queue count");

    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_wp <= r_rp && r_rp < r_count))
        else $error("queue compaction pointers out of order");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_cmd.ready)
        else $error("command taken during a queue walk");

endmodule
